// ===== hdl/ptc_pkg.sv =====
// Shared types and constants for the pressure/temperature compensation unit.
// Used by pressure_temperature_compensation_unit; depends on nothing else.
package ptc_pkg;

   localparam int CalRegs  = 6;
   localparam int CsrIdxW  = 3;
   localparam int RawW     = 20;
   localparam int DivW     = 64;

   // calibration register indexes
   localparam logic [CsrIdxW-1:0] CSR_CAL_TEMP_A  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_CAL_TEMP_B  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_CAL_PRESS_A = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_CAL_PRESS_B = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_CAL_PRESS_C = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_CAL_PRESS_D = 3'd5;

   typedef struct packed {
      logic [RawW-1:0] raw_temperature;
      logic [RawW-1:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic signed [31:0] fine_temperature_out;
      logic        [31:0] pressure_q24_8;
      logic               divisor_zero;
   } rsp_type;

endpackage

// ===== hdl/pressure_temperature_compensation_unit.sv =====
// Top level of the pressure/temperature compensation unit: 32-bit temperature
// path, 64-bit pressure path and a pipelined signed 64-bit divider.
// Depends on ptc_pkg.

// One word enters per cycle while the pipeline is not frozen; the pipeline's
// length is set mostly by the radix-2 divider, one quotient bit per stage over 64
// stages. The pipeline freezes only while the output skid register holds a
// word that has not been taken. Calibration registers must be written while
// the unit is empty; writes to indexes six and seven are dropped.
module pressure_temperature_compensation_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  ptc_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ptc_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ptc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [31:0]                  csr_data
);
   import ptc_pkg::*;

   localparam int PreSt = 13;
   localparam int PostSt = 7;
   localparam int NSt = PreSt + DivW + PostSt;
   localparam int DivLast = PreSt + DivW - 1;

   typedef struct packed {
      logic [31:0] centi;
      logic [31:0] fine;
   } ptc_side_type;

   logic [31:0]    cal_ff [CalRegs];
   logic [NSt-1:0] vld_ff;
   logic           en;
   logic           skid_full_ff;
   rsp_type        skid_ff;
   rsp_type        last_w;

   // calibration words
   logic [15:0]        t1;
   logic [31:0]        t2w, t3w, p6w, p3w, p8w, p9w;
   logic [15:0]        p1;
   logic signed [15:0] p2s, p3s, p4s, p5s, p6s, p7s, p8s, p9s;

   assign t1  = cal_ff[0][15:0];
   assign t2w = {{16{cal_ff[0][31]}}, cal_ff[0][31:16]};
   assign t3w = {{16{cal_ff[1][15]}}, cal_ff[1][15:0]};
   assign p1  = cal_ff[1][31:16];
   assign p2s = $signed(cal_ff[2][15:0]);
   assign p3s = $signed(cal_ff[2][31:16]);
   assign p4s = $signed(cal_ff[3][15:0]);
   assign p5s = $signed(cal_ff[3][31:16]);
   assign p6s = $signed(cal_ff[4][15:0]);
   assign p7s = $signed(cal_ff[4][31:16]);
   assign p8s = $signed(cal_ff[5][15:0]);
   assign p9s = $signed(cal_ff[5][31:16]);
   assign p3w = {{16{p3s[15]}}, p3s};
   assign p6w = {{16{p6s[15]}}, p6s};
   assign p8w = {{16{p8s[15]}}, p8s};
   assign p9w = {{16{p9s[15]}}, p9s};

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CalRegs; i++) cal_ff[i] <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CAL_TEMP_A:  cal_ff[0] <= csr_data;
            CSR_CAL_TEMP_B:  cal_ff[1] <= csr_data;
            CSR_CAL_PRESS_A: cal_ff[2] <= csr_data;
            CSR_CAL_PRESS_B: cal_ff[3] <= csr_data;
            CSR_CAL_PRESS_C: cal_ff[4] <= csr_data;
            CSR_CAL_PRESS_D: cal_ff[5] <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   assign en        = !skid_full_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSt-2:0], req_valid};
      end
   end

   // ---------------- temperature path ----------------
   logic [31:0] s1_a_ff, s1_d_ff;
   logic [20:0] s1_p0_ff;
   logic [31:0] s2_m1_ff, s2_dd_ff;
   logic [20:0] s2_p0_ff;
   logic [31:0] s3_ta_ff, s3_m2_ff;
   logic [20:0] s3_p0_ff;
   logic [31:0] s4_fine_ff;
   logic [20:0] s4_p0_ff;
   logic [31:0] s5_f5_ff, s5_fine_ff;
   logic signed [32:0] s5_x_ff;
   logic [20:0] s5_p0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_a_ff  <= {15'd0, req_data.raw_temperature[19:3]} - {15'd0, t1, 1'b0};
         s1_d_ff  <= {16'd0, req_data.raw_temperature[19:4]} - {16'd0, t1};
         s1_p0_ff <= 21'd1048576 - {1'b0, req_data.raw_pressure};

         s2_m1_ff <= s1_a_ff * t2w;
         s2_dd_ff <= s1_d_ff * s1_d_ff;
         s2_p0_ff <= s1_p0_ff;

         s3_ta_ff <= 32'($signed(s2_m1_ff) >>> 11);
         s3_m2_ff <= 32'($signed(s2_dd_ff) >>> 12) * t3w;
         s3_p0_ff <= s2_p0_ff;

         s4_fine_ff <= s3_ta_ff + 32'($signed(s3_m2_ff) >>> 14);
         s4_p0_ff   <= s3_p0_ff;

         s5_f5_ff   <= {s4_fine_ff[29:0], 2'b00} + s4_fine_ff + 32'd128;
         s5_x_ff    <= $signed({s4_fine_ff[31], s4_fine_ff}) - 33'sd128000;
         s5_fine_ff <= s4_fine_ff;
         s5_p0_ff   <= s4_p0_ff;
      end
   end

   // ---------------- pressure path, divisor and numerator ----------------
   logic signed [65:0] sq_full_w;
   logic signed [48:0] xp5_w, xp2_w, pp6lo_w, pp3lo_w;
   assign sq_full_w = s5_x_ff * s5_x_ff;
   assign xp5_w     = s5_x_ff * p5s;
   assign xp2_w     = s5_x_ff * p2s;

   ptc_side_type       s6_side_ff, s7_side_ff, s8_side_ff, s9_side_ff;
   ptc_side_type       s10_side_ff, s11_side_ff, s12_side_ff;
   logic [63:0]        s6_sq_ff;
   logic signed [48:0] s6_xp5_ff, s6_xp2_ff, s7_xp5_ff, s7_xp2_ff, s8_xp5_ff, s8_xp2_ff;
   logic [20:0]        s6_p0_ff, s7_p0_ff, s8_p0_ff, s9_p0_ff;
   logic signed [48:0] s7_pp6lo_ff, s7_pp3lo_ff;
   logic [31:0]        s7_pp6hi_ff, s7_pp3hi_ff;
   logic [63:0]        s8_y1_ff, s8_x3_ff;
   logic [63:0]        s9_y_ff, s9_x1_ff;
   logic [63:0]        s10_v_ff, s10_t_ff;
   logic [47:0]        s11_plo_ff;
   logic [31:0]        s11_phi_ff;
   logic [63:0]        s11_t_ff;
   logic [63:0]        s12_vp_ff, s12_num_ff;

   assign pp6lo_w = $signed({1'b0, s6_sq_ff[31:0]}) * p6s;
   assign pp3lo_w = $signed({1'b0, s6_sq_ff[31:0]}) * p3s;

   always_ff @(posedge clock) begin
      if (en) begin
         s6_side_ff <= '{centi: 32'($signed(s5_f5_ff) >>> 8), fine: s5_fine_ff};
         s6_sq_ff   <= sq_full_w[63:0];
         s6_xp5_ff  <= xp5_w;
         s6_xp2_ff  <= xp2_w;
         s6_p0_ff   <= s5_p0_ff;

         s7_side_ff  <= s6_side_ff;
         s7_pp6lo_ff <= pp6lo_w;
         s7_pp3lo_ff <= pp3lo_w;
         s7_pp6hi_ff <= s6_sq_ff[63:32] * p6w;
         s7_pp3hi_ff <= s6_sq_ff[63:32] * p3w;
         s7_xp5_ff   <= s6_xp5_ff;
         s7_xp2_ff   <= s6_xp2_ff;
         s7_p0_ff    <= s6_p0_ff;

         s8_side_ff <= s7_side_ff;
         s8_y1_ff   <= {{15{s7_pp6lo_ff[48]}}, s7_pp6lo_ff} + {s7_pp6hi_ff, 32'd0};
         s8_x3_ff   <= {{15{s7_pp3lo_ff[48]}}, s7_pp3lo_ff} + {s7_pp3hi_ff, 32'd0};
         s8_xp5_ff  <= s7_xp5_ff;
         s8_xp2_ff  <= s7_xp2_ff;
         s8_p0_ff   <= s7_p0_ff;

         s9_side_ff <= s8_side_ff;
         s9_y_ff    <= s8_y1_ff + ({{15{s8_xp5_ff[48]}}, s8_xp5_ff} << 17)
                       + ({{48{p4s[15]}}, p4s} << 35);
         s9_x1_ff   <= 64'($signed(s8_x3_ff) >>> 8) + ({{15{s8_xp2_ff[48]}}, s8_xp2_ff} << 12);
         s9_p0_ff   <= s8_p0_ff;

         s10_side_ff <= s9_side_ff;
         s10_v_ff    <= 64'h0000_8000_0000_0000 + s9_x1_ff;
         s10_t_ff    <= ({43'd0, s9_p0_ff} << 31) - s9_y_ff;

         s11_side_ff <= s10_side_ff;
         s11_plo_ff  <= s10_v_ff[31:0] * p1;
         s11_phi_ff  <= s10_v_ff[63:32] * {16'd0, p1};
         s11_t_ff    <= s10_t_ff;

         s12_side_ff <= s11_side_ff;
         s12_vp_ff   <= {16'd0, s11_plo_ff} + {s11_phi_ff, 32'd0};
         s12_num_ff  <= s11_t_ff * 64'd3125;
      end
   end

   // ---------------- divider: prepare, then one quotient bit per stage ----------------
   logic [63:0]  dv_rem_ff  [DivW+1];
   logic [63:0]  dv_nq_ff   [DivW+1];
   logic [63:0]  dv_d_ff    [DivW+1];
   ptc_side_type dv_side_ff [DivW+1];
   logic         dv_zero_ff [DivW+1];
   logic         dv_neg_ff  [DivW+1];

   logic [63:0] xd_w;
   assign xd_w = 64'($signed(s12_vp_ff) >>> 33);

   always_ff @(posedge clock) begin
      if (en) begin
         dv_rem_ff[0]  <= '0;
         dv_nq_ff[0]   <= s12_num_ff[63] ? (64'd0 - s12_num_ff) : s12_num_ff;
         // a zero divisor is replaced so the stages stay well defined
         dv_d_ff[0]    <= (xd_w == 64'd0) ? 64'd1 : (xd_w[63] ? (64'd0 - xd_w) : xd_w);
         dv_zero_ff[0] <= (xd_w == 64'd0);
         dv_neg_ff[0]  <= s12_num_ff[63] ^ xd_w[63];
         dv_side_ff[0] <= s12_side_ff;
      end
   end

   for (genvar k = 0; k < DivW; k++) begin : g_div
      logic [64:0] sh_w;
      logic [64:0] df_w;
      always_comb begin
         sh_w = {dv_rem_ff[k], dv_nq_ff[k][63]};
         df_w = sh_w - {1'b0, dv_d_ff[k]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[k+1]  <= df_w[64] ? sh_w[63:0] : df_w[63:0];
            dv_nq_ff[k+1]   <= {dv_nq_ff[k][62:0], !df_w[64]};
            dv_d_ff[k+1]    <= dv_d_ff[k];
            dv_zero_ff[k+1] <= dv_zero_ff[k];
            dv_neg_ff[k+1]  <= dv_neg_ff[k];
            dv_side_ff[k+1] <= dv_side_ff[k];
         end
      end
   end

   // ---------------- pressure correction after the quotient ----------------
   logic [63:0]        q_w;
   assign q_w = dv_neg_ff[DivW] ? (64'd0 - dv_nq_ff[DivW]) : dv_nq_ff[DivW];

   ptc_side_type       d1_side_ff, d2_side_ff, d3_side_ff, d4_side_ff, d5_side_ff;
   ptc_side_type       d6_side_ff;
   logic               d1_zero_ff, d2_zero_ff, d3_zero_ff, d4_zero_ff, d5_zero_ff;
   logic               d6_zero_ff;
   logic [63:0]        d1_q_ff, d1_ps_ff, d2_q_ff, d3_q_ff, d4_q_ff, d5_q_ff;
   logic [63:0]        d2_ll_ff;
   logic [31:0]        d2_lh_ff, d2_c8hi_ff;
   logic signed [48:0] d2_c8lo_ff, d4_c9lo_ff;
   logic [63:0]        d3_sq2_ff, d3_c8_ff, d4_c8_ff, d5_c8_ff, d5_c9_ff;
   logic [31:0]        d4_c9hi_ff;
   logic [63:0]        d6_s_ff;
   rsp_type            d7_rsp_ff;
   logic signed [48:0] c8lo_w, c9lo_w;
   logic [63:0]        press_w;

   assign c8lo_w  = $signed({1'b0, d1_q_ff[31:0]}) * p8s;
   assign c9lo_w  = $signed({1'b0, d3_sq2_ff[31:0]}) * p9s;
   assign press_w = 64'($signed(d6_s_ff) >>> 8) + ({{48{p7s[15]}}, p7s} << 4);

   always_ff @(posedge clock) begin
      if (en) begin
         d1_side_ff <= dv_side_ff[DivW];
         d1_zero_ff <= dv_zero_ff[DivW];
         d1_q_ff    <= q_w;
         d1_ps_ff   <= 64'($signed(q_w) >>> 13);

         d2_side_ff <= d1_side_ff;
         d2_zero_ff <= d1_zero_ff;
         d2_q_ff    <= d1_q_ff;
         d2_ll_ff   <= d1_ps_ff[31:0] * d1_ps_ff[31:0];
         d2_lh_ff   <= d1_ps_ff[31:0] * d1_ps_ff[63:32];
         d2_c8lo_ff <= c8lo_w;
         d2_c8hi_ff <= d1_q_ff[63:32] * p8w;

         // cross term appears twice: shift by 33
         d3_side_ff <= d2_side_ff;
         d3_zero_ff <= d2_zero_ff;
         d3_q_ff    <= d2_q_ff;
         d3_sq2_ff  <= d2_ll_ff + {d2_lh_ff[30:0], 33'd0};
         d3_c8_ff   <= {{15{d2_c8lo_ff[48]}}, d2_c8lo_ff} + {d2_c8hi_ff, 32'd0};

         d4_side_ff <= d3_side_ff;
         d4_zero_ff <= d3_zero_ff;
         d4_q_ff    <= d3_q_ff;
         d4_c8_ff   <= d3_c8_ff;
         d4_c9lo_ff <= c9lo_w;
         d4_c9hi_ff <= d3_sq2_ff[63:32] * p9w;

         d5_side_ff <= d4_side_ff;
         d5_zero_ff <= d4_zero_ff;
         d5_q_ff    <= d4_q_ff;
         d5_c8_ff   <= d4_c8_ff;
         d5_c9_ff   <= {{15{d4_c9lo_ff[48]}}, d4_c9lo_ff} + {d4_c9hi_ff, 32'd0};

         d6_side_ff <= d5_side_ff;
         d6_zero_ff <= d5_zero_ff;
         d6_s_ff    <= d5_q_ff + 64'($signed(d5_c9_ff) >>> 25)
                       + 64'($signed(d5_c8_ff) >>> 19);

         d7_rsp_ff.temperature_centi    <= $signed(d6_side_ff.centi);
         d7_rsp_ff.fine_temperature_out <= $signed(d6_side_ff.fine);
         d7_rsp_ff.pressure_q24_8       <= d6_zero_ff ? 32'd0 : press_w[31:0];
         d7_rsp_ff.divisor_zero         <= d6_zero_ff;
      end
   end

   // ---------------- output skid ----------------
   assign last_w = d7_rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp_ready) skid_full_ff <= 1'b0;
      end else if (vld_ff[NSt-1] && !rsp_ready) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      // hold the unclaimed word while the pipeline advances once more
      if (!skid_full_ff) skid_ff <= last_w;
   end

   assign rsp_valid = skid_full_ff || vld_ff[NSt-1];
   assign rsp_data  = skid_full_ff ? skid_ff : last_w;

   // ---------------- assertions ----------------
   a_zero_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divisor_zero |-> rsp_data.pressure_q24_8 == 32'd0)
      else $error("pressure not cleared on zero divisor");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |=> $stable(vld_ff))
      else $error("pipeline moved while skid full");

   a_skid_src: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(vld_ff[NSt-1]))
      else $error("skid filled without a word");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DivLast] |-> dv_rem_ff[DivW] < dv_d_ff[DivW])
      else $error("divider remainder not below divisor");

endmodule
